### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the spring force accumulator.
// Both expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds in the same cycle as its trigger.
`define SFA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequence checked in the cycle after the trigger.
`define SFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/sfa_pkg.sv
// Package for the spring force accumulator: queue entry type, back-end states,
// constants and small arithmetic helpers. No dependencies.
package sfa_pkg;

	localparam logic [15:0] STIFF_RESET     = 16'd640;
	localparam int          SFA_QUEUE_DEPTH = 2;

	localparam logic signed [48:0] ACC_MAX = 49'sh0_7fff_ffff_ffff;
	localparam logic signed [48:0] ACC_MIN = -49'sh0_8000_0000_0000;
	localparam logic signed [47:0] OUT_MAX = 48'sh0000_7fff_ffff;
	localparam logic signed [47:0] OUT_MIN = -48'sh0000_8000_0000;

	typedef struct packed {
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [32:0] dz;
		logic [30:0]        rest;
		logic               last;
		logic               zero;
	} spring_t;

	typedef struct packed {
		logic pop;
		logic zero_seen;
	} back_stat_t;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_SQ    = 9'b000000010,
		ST_GO    = 9'b000000100,
		ST_ROOT  = 9'b000001000,
		ST_PROD  = 9'b000010000,
		ST_DIV   = 9'b000100000,
		ST_TERM  = 9'b001000000,
		ST_FORCE = 9'b010000000,
		ST_FIN   = 9'b100000000
	} back_state_t;

	function automatic logic [31:0] mag33(input logic signed [32:0] d);
		logic [32:0] n;
		n = -d;
		return d[32] ? n[31:0] : d[31:0];
	endfunction

	function automatic logic out_ovf(input logic signed [47:0] s);
		return (s > OUT_MAX) || (s < OUT_MIN);
	endfunction

	function automatic logic [31:0] out_sat(input logic signed [47:0] s);
		logic [31:0] r;
		if (s > OUT_MAX) begin
			r = 32'h7fff_ffff;
		end else if (s < OUT_MIN) begin
			r = 32'h8000_0000;
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

endpackage

### rtl/core/spring_force_accumulator_unit.sv
// Spring force accumulator top level: stiffness register, front end, spring
// queue and back end. Depends on sfa_pkg, sfa_front, sfa_queue, sfa_back.
//
// Each spring whose length is not zero passes through the back end's 33-step
// square root of the squared length and the 31-step restoring divider that
// scales the rest length; a zero-length spring skips both. The front end and a
// short queue keep taking springs meanwhile. A result appears after the spring
// marked last and waits in an output register.
`include "assert_macros.svh"

module spring_force_accumulator_unit import sfa_pkg::*; #(
	parameter int QUEUE_DEPTH = SFA_QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] vertex_x,
	input  logic signed [31:0] vertex_y,
	input  logic signed [31:0] vertex_z,
	input  logic signed [31:0] neighbor_x,
	input  logic signed [31:0] neighbor_y,
	input  logic signed [31:0] neighbor_z,
	input  logic [30:0]        rest_length,
	input  logic               last_spring,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] force_x,
	output logic signed [31:0] force_y,
	output logic signed [31:0] force_z,
	output logic               degenerate,
	output logic               clipped
);

	logic [15:0] stiffness_q;
	logic        q_push, q_full, q_empty;
	spring_t     q_wdata, q_head;
	back_stat_t  back_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiffness_q <= STIFF_RESET;
		end else if (cfg_we) begin
			stiffness_q <= cfg_wdata;
		end
	end

	sfa_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.vertex_x    (vertex_x),
		.vertex_y    (vertex_y),
		.vertex_z    (vertex_z),
		.neighbor_x  (neighbor_x),
		.neighbor_y  (neighbor_y),
		.neighbor_z  (neighbor_z),
		.rest_length (rest_length),
		.last_spring (last_spring),
		.push        (q_push),
		.push_data   (q_wdata),
		.q_full      (q_full)
	);

	sfa_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.pop       (back_stat.pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	sfa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.stiffness  (stiffness_q),
		.head       (q_head),
		.q_empty    (q_empty),
		.stat       (back_stat),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.force_x    (force_x),
		.force_y    (force_y),
		.force_z    (force_z),
		.degenerate (degenerate),
		.clipped    (clipped)
	);

	`SFA_ASSERT(a_stall_only_full, in_stall |-> q_full, "input stalled with queue space free")
	`SFA_ASSERT(a_pop_nonempty, back_stat.pop |-> !q_empty, "pop from empty spring queue")
	`SFA_ASSERT(a_clip_sat, (out_valid && clipped) |-> (force_x == 32'h7fffffff || force_x == 32'h80000000 || force_y == 32'h7fffffff || force_y == 32'h80000000 || force_z == 32'h7fffffff || force_z == 32'h80000000), "clipped without a saturated component")
	`SFA_ASSERT_NEXT(a_zero_sticky, back_stat.pop && q_head.zero, back_stat.zero_seen, "zero-length spring not flagged")

endmodule

### rtl/core/sfa_front.sv
// Front end: registers an incoming spring, forms the difference vector and
// flags zero length. Depends on sfa_pkg.
module sfa_front import sfa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] vertex_x,
	input  logic signed [31:0] vertex_y,
	input  logic signed [31:0] vertex_z,
	input  logic signed [31:0] neighbor_x,
	input  logic signed [31:0] neighbor_y,
	input  logic signed [31:0] neighbor_z,
	input  logic [30:0]        rest_length,
	input  logic               last_spring,
	output logic               push,
	output spring_t            push_data,
	input  logic               q_full
);

	logic    vld_s1;
	spring_t item_s1;
	logic    take;
	logic signed [32:0] dx, dy, dz;

	assign push     = vld_s1 && !q_full;
	assign in_stall = vld_s1 && q_full;
	assign take     = in_valid && !in_stall;

	assign dx = 33'(neighbor_x) - 33'(vertex_x);
	assign dy = 33'(neighbor_y) - 33'(vertex_y);
	assign dz = 33'(neighbor_z) - 33'(vertex_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.dx   <= dx;
			item_s1.dy   <= dy;
			item_s1.dz   <= dz;
			item_s1.rest <= rest_length;
			item_s1.last <= last_spring;
			item_s1.zero <= (dx == '0) && (dy == '0) && (dz == '0);
		end
	end

	assign push_data = item_s1;

endmodule

### rtl/core/sfa_queue.sv
// Short spring queue between front and back end.
// Depends on sfa_pkg.
module sfa_queue import sfa_pkg::*; #(
	parameter int DEPTH = SFA_QUEUE_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  spring_t push_data,
	input  logic    pop,
	output spring_t head,
	output logic    full,
	output logic    empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	spring_t        mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### rtl/core/sfa_isqrt.sv
// Digit-by-digit integer square root of a 66-bit radicand, one root bit
// per cycle. Self-contained.
module sfa_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [65:0] radicand,
	output logic        done,
	output logic [32:0] root
);

	logic        busy_q, done_q;
	logic [5:0]  cnt_q;
	logic [65:0] sh_q;
	logic [34:0] rem_q;
	logic [32:0] root_q;
	logic [36:0] remn, trial;
	logic        fit;

	assign remn  = {rem_q, sh_q[65:64]};
	assign trial = {2'b00, root_q, 2'b01};
	assign fit   = (remn >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'd32) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q   <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			sh_q   <= {sh_q[63:0], 2'b00};
			rem_q  <= fit ? 35'(remn - trial) : remn[34:0];
			root_q <= {root_q[31:0], fit};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

### rtl/core/sfa_back.sv
// Back end: length, per-axis spring term, force scaling, accumulation and
// result register. Depends on sfa_pkg and sfa_isqrt.
module sfa_back import sfa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [15:0]        stiffness,
	input  spring_t            head,
	input  logic               q_empty,
	output back_stat_t         stat,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] force_x,
	output logic signed [31:0] force_y,
	output logic signed [31:0] force_z,
	output logic               degenerate,
	output logic               clipped
);

	back_state_t state_q;
	spring_t     item_q;
	logic [4:0]  cnt_q;
	logic [1:0]  ax, ax_prev;
	logic [65:0] rad_q;
	logic [63:0] prod_q;
	logic [32:0] len_q;
	logic [32:0] rem_q [3];
	logic [30:0] lo_q  [3];
	logic signed [33:0] term_q [3];
	logic signed [41:0] f_s1;
	logic signed [47:0] sum_q [3];
	logic        zero_q;
	logic        out_valid_q;
	logic        pop, out_free;
	logic        sq_start, sq_done;
	logic [32:0] sq_root;
	logic signed [32:0] dsel;
	logic [31:0] msel;
	logic [62:0] dvd;
	logic signed [33:0] tsel;
	logic [32:0] tmag;
	logic [48:0] fprod;
	logic [40:0] fmag;
	logic signed [41:0] fval;
	logic signed [48:0] acc_t;
	logic signed [32:0] d_ax [3];

	sfa_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (rad_q),
		.done     (sq_done),
		.root     (sq_root)
	);

	assign ax       = cnt_q[1:0];
	assign ax_prev  = ax - 2'd1;
	assign pop      = (state_q == ST_IDLE) && !q_empty;
	assign out_free = !out_valid_q || !out_stall;
	assign sq_start = (state_q == ST_GO);

	assign d_ax[0] = item_q.dx;
	assign d_ax[1] = item_q.dy;
	assign d_ax[2] = item_q.dz;

	always_comb begin
		case (ax)
			2'd0:    dsel = item_q.dx;
			2'd1:    dsel = item_q.dy;
			default: dsel = item_q.dz;
		endcase
		case (ax)
			2'd0:    tsel = term_q[0];
			2'd1:    tsel = term_q[1];
			default: tsel = term_q[2];
		endcase
	end

	assign msel  = mag33(dsel);
	assign dvd   = 63'(item_q.rest) * 63'(msel);
	assign tmag  = tsel[33] ? 33'(-tsel) : tsel[32:0];
	assign fprod = 49'(stiffness) * 49'(tmag);
	assign fmag  = fprod[48:8];
	assign fval  = tsel[33] ? -$signed({1'b0, fmag}) : $signed({1'b0, fmag});
	assign acc_t = 49'(sum_q[ax_prev]) + 49'(f_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && item_q.last && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			zero_q      <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				sum_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (pop) begin
						if (head.zero) begin
							zero_q  <= 1'b1;
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_SQ;
						end
					end
				end
				ST_SQ: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'd3) begin
						state_q <= ST_GO;
					end
				end
				ST_GO: begin
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					cnt_q <= '0;
					if (sq_done) begin
						state_q <= ST_PROD;
					end
				end
				ST_PROD: begin
					if (cnt_q == 5'd2) begin
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (cnt_q == 5'd30) begin
						cnt_q   <= '0;
						state_q <= ST_TERM;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_TERM: begin
					state_q <= ST_FORCE;
				end
				ST_FORCE: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q != 5'd0) begin
						if (acc_t > ACC_MAX) begin
							sum_q[ax_prev] <= ACC_MAX[47:0];
						end else if (acc_t < ACC_MIN) begin
							sum_q[ax_prev] <= ACC_MIN[47:0];
						end else begin
							sum_q[ax_prev] <= acc_t[47:0];
						end
					end
					if (cnt_q == 5'd3) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!item_q.last) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						zero_q      <= 1'b0;
						for (int i = 0; i < 3; i++) begin
							sum_q[i] <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head;
		end
		if (state_q == ST_SQ) begin
			if (cnt_q == 5'd0) begin
				rad_q <= '0;
			end else begin
				rad_q <= rad_q + 66'(prod_q);
			end
			prod_q <= 64'(msel) * 64'(msel);
		end
		if (state_q == ST_ROOT && sq_done) begin
			len_q <= sq_root;
		end
		if (state_q == ST_PROD) begin
			rem_q[ax] <= {1'b0, dvd[62:31]};
			lo_q[ax]  <= dvd[30:0];
		end
		if (state_q == ST_DIV) begin
			for (int i = 0; i < 3; i++) begin
				if ({rem_q[i], lo_q[i][30]} >= {1'b0, len_q}) begin
					rem_q[i] <= 33'({rem_q[i], lo_q[i][30]} - {1'b0, len_q});
					lo_q[i]  <= {lo_q[i][29:0], 1'b1};
				end else begin
					rem_q[i] <= {rem_q[i][31:0], lo_q[i][30]};
					lo_q[i]  <= {lo_q[i][29:0], 1'b0};
				end
			end
		end
		if (state_q == ST_TERM) begin
			for (int i = 0; i < 3; i++) begin
				if (d_ax[i][32]) begin
					term_q[i] <= 34'(d_ax[i]) + $signed({3'b000, lo_q[i]});
				end else begin
					term_q[i] <= 34'(d_ax[i]) - $signed({3'b000, lo_q[i]});
				end
			end
		end
		if (state_q == ST_FORCE) begin
			f_s1 <= fval;
		end
		if (state_q == ST_FIN && item_q.last && out_free) begin
			force_x    <= out_sat(sum_q[0]);
			force_y    <= out_sat(sum_q[1]);
			force_z    <= out_sat(sum_q[2]);
			degenerate <= zero_q;
			clipped    <= out_ovf(sum_q[0]) || out_ovf(sum_q[1]) || out_ovf(sum_q[2]);
		end
	end

	assign out_valid      = out_valid_q;
	assign stat.pop       = pop;
	assign stat.zero_seen = zero_q;

endmodule
